>>> rtl/usm_pkg.sv
// Shared types, constants and the Gaussian weight table for the unsharp-mask sharpener.
// No dependencies; used by usm_ctrl, usm_dp and unsharp_mask_sharpen_rgba.
package usm_pkg;

   localparam int KernelRadius    = 3;
   localparam int Taps            = 2 * KernelRadius + 1;
   localparam int TapBits         = $clog2(Taps);
   localparam int Slots           = 2 * KernelRadius + 2;
   localparam int SlotBits        = $clog2(Slots);
   localparam int WeightBits      = 16;
   localparam int AccBits         = WeightBits + 8 + 6;
   localparam int MaxHeight       = 4096;
   localparam int RowBits         = 13;
   localparam int DefaultMaxWidth = 1024;
   localparam int CsrIndexBits    = 2;
   localparam int CsrDataBits     = 13;

   localparam logic [10:0] ResetWidth  = 11'd1024;
   localparam logic [12:0] ResetHeight = 13'd768;
   localparam logic [7:0]  ResetGain   = 8'd24;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SHARPEN_GAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_opacity;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_opacity;
      logic       last_of_frame;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_CHECK, ST_TAP_RD, ST_TAP_ACC, ST_CEN_RD, ST_SHARP, ST_PUSH
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic clear_acc;
      logic tap_rd;
      logic tap_acc;
      logic cen_rd;
      logic sharpen;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic pending;
      logic last_tap;
      logic out_free;
   } sts_type;

   // exp(-(i*i+j*j)/2) in Q0.24, indexed by |i|, |j|
   localparam longint unsigned GaussQ24 [4][4] = '{
      '{64'd16777216, 64'd10175896, 64'd2270549, 64'd186377},
      '{64'd10175896, 64'd6171993,  64'd1377158, 64'd113044},
      '{64'd2270549,  64'd1377158,  64'd307285,  64'd25223},
      '{64'd186377,   64'd113044,   64'd25223,   64'd2070}
   };

   function automatic longint unsigned gauss_sum();
      longint unsigned s;
      s = 0;
      for (int i = -KernelRadius; i <= KernelRadius; i++) begin
         for (int j = -KernelRadius; j <= KernelRadius; j++) begin
            s += GaussQ24[(i < 0) ? -i : i][(j < 0) ? -j : j];
         end
      end
      return s;
   endfunction

   localparam longint unsigned GaussSum = gauss_sum();

   // Round half up of g / sum in Q0.WeightBits; elaboration only.
   function automatic logic [WeightBits-1:0] weight_of(int ai, int aj);
      longint unsigned g;
      g = GaussQ24[ai][aj];
      return WeightBits'(((g << WeightBits) + GaussSum / 2) / GaussSum);
   endfunction

   localparam logic [WeightBits-1:0] WeightRom [4][4] = '{
      '{weight_of(0, 0), weight_of(0, 1), weight_of(0, 2), weight_of(0, 3)},
      '{weight_of(1, 0), weight_of(1, 1), weight_of(1, 2), weight_of(1, 3)},
      '{weight_of(2, 0), weight_of(2, 1), weight_of(2, 2), weight_of(2, 3)},
      '{weight_of(3, 0), weight_of(3, 1), weight_of(3, 2), weight_of(3, 3)}
   };

endpackage

>>> rtl/usm_ctrl.sv
// Sequencer for the sharpener: walks one transaction through update, check, taps and output.
// Depends on usm_pkg (state, command and status types).
module usm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  usm_pkg::sts_type sts,
   output usm_pkg::cmd_type cmd
);

   usm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         usm_pkg::ST_IDLE: begin
            if (req_valid) state_in = usm_pkg::ST_PREP;
         end
         usm_pkg::ST_PREP:    state_in = usm_pkg::ST_CHECK;
         usm_pkg::ST_CHECK: begin
            state_in = sts.pending ? usm_pkg::ST_TAP_RD : usm_pkg::ST_IDLE;
         end
         usm_pkg::ST_TAP_RD:  state_in = usm_pkg::ST_TAP_ACC;
         usm_pkg::ST_TAP_ACC: begin
            state_in = sts.last_tap ? usm_pkg::ST_CEN_RD : usm_pkg::ST_TAP_RD;
         end
         usm_pkg::ST_CEN_RD:  state_in = usm_pkg::ST_SHARP;
         usm_pkg::ST_SHARP:   state_in = usm_pkg::ST_PUSH;
         usm_pkg::ST_PUSH: begin
            if (sts.out_free) state_in = usm_pkg::ST_IDLE;
         end
         default:             state_in = usm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         usm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         usm_pkg::ST_PREP:    cmd.prep = 1'b1;
         usm_pkg::ST_CHECK:   cmd.clear_acc = 1'b1;
         usm_pkg::ST_TAP_RD:  cmd.tap_rd = 1'b1;
         usm_pkg::ST_TAP_ACC: cmd.tap_acc = 1'b1;
         usm_pkg::ST_CEN_RD:  cmd.cen_rd = 1'b1;
         usm_pkg::ST_SHARP:   cmd.sharpen = 1'b1;
         usm_pkg::ST_PUSH:    cmd.push = sts.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/usm_dp.sv
// Datapath: config registers, position counters, row store, 7x7 MAC and sharpen, output register.
// Depends on usm_pkg; driven by usm_ctrl commands.
module usm_dp #(
   parameter int MAX_WIDTH = usm_pkg::DefaultMaxWidth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [usm_pkg::CsrIndexBits-1:0]      csr_index,
   input  logic [usm_pkg::CsrDataBits-1:0]       csr_wdata,
   input  usm_pkg::req_data_type                 req_data,
   input  usm_pkg::cmd_type                      cmd,
   output usm_pkg::sts_type                      sts,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output usm_pkg::rsp_data_type                 rsp_data
);

   localparam int ColBits  = $clog2(MAX_WIDTH);
   localparam int WBits    = ColBits + 1;
   localparam int Depth    = usm_pkg::Slots * MAX_WIDTH;
   localparam int AddrBits = $clog2(Depth);
   localparam int RowBits  = usm_pkg::RowBits;
   localparam int TapBits  = usm_pkg::TapBits;
   localparam int AccBits  = usm_pkg::AccBits;
   localparam int WtBits   = usm_pkg::WeightBits;
   localparam int Kr       = usm_pkg::KernelRadius;

   function automatic logic [AddrBits-1:0] addr_of(logic [usm_pkg::SlotBits-1:0] slot,
                                                   logic [ColBits-1:0] col);
      return AddrBits'(slot) * AddrBits'(MAX_WIDTH) + AddrBits'(col);
   endfunction

   function automatic logic [7:0] sharpen(logic [7:0] orig, logic [7:0] blur,
                                          logic [7:0] gain);
      logic signed [8:0]  diff;
      logic signed [17:0] prod;
      logic signed [19:0] v;
      diff = $signed({1'b0, orig}) - $signed({1'b0, blur});
      prod = $signed({1'b0, gain}) * diff;
      v    = $signed({8'b0, orig, 4'b0}) + 20'(prod);
      if (v[19]) return 8'd0;
      if (v[19:4] > 16'd255) return 8'd255;
      return v[11:4];
   endfunction

   function automatic logic [7:0] blur_of(logic [AccBits-1:0] acc);
      if (acc[AccBits-1:WtBits] > (AccBits-WtBits)'(255)) return 8'd255;
      return acc[WtBits+7:WtBits];
   endfunction

   // configuration
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [7:0]  gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= usm_pkg::ResetWidth;
         height_ff <= usm_pkg::ResetHeight;
         gain_ff   <= usm_pkg::ResetGain;
      end else if (csr_we) begin
         case (csr_index)
            usm_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[10:0];
            usm_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[12:0];
            usm_pkg::CSR_SHARPEN_GAIN: gain_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [WBits-1:0]   eff_w;
   logic [RowBits-1:0] eff_h;

   always_comb begin
      if (width_ff == '0) eff_w = WBits'(1);
      else if (14'(width_ff) > 14'(MAX_WIDTH)) eff_w = WBits'(MAX_WIDTH);
      else eff_w = WBits'(width_ff);
      if (height_ff == '0) eff_h = RowBits'(1);
      else if (14'(height_ff) > 14'(usm_pkg::MaxHeight)) eff_h = RowBits'(usm_pkg::MaxHeight);
      else eff_h = height_ff;
   end

   // captured transaction
   usm_pkg::req_data_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   // position counters
   logic [ColBits-1:0] in_col_ff, out_col_ff;
   logic [RowBits-1:0] in_row_ff, out_row_ff;
   logic               frame_done, is_pixel;
   logic [ColBits-1:0] c_in_col, c_out_col, adv_in_col, adv_out_col;
   logic [RowBits-1:0] c_in_row, c_out_row, adv_in_row, adv_out_row;
   logic [WBits-1:0]   in_col_inc, out_col_inc;

   always_comb begin
      frame_done = out_row_ff >= eff_h;
      c_in_col   = frame_done ? '0 : in_col_ff;
      c_in_row   = frame_done ? '0 : in_row_ff;
      c_out_col  = frame_done ? '0 : out_col_ff;
      c_out_row  = frame_done ? '0 : out_row_ff;
      is_pixel   = (req_ff.mode == usm_pkg::MODE_PIXEL) && (c_in_row < eff_h);

      in_col_inc = WBits'(c_in_col) + WBits'(1);
      if (in_col_inc >= eff_w) begin
         adv_in_col = '0;
         adv_in_row = c_in_row + RowBits'(1);
      end else begin
         adv_in_col = in_col_inc[ColBits-1:0];
         adv_in_row = c_in_row;
      end

      out_col_inc = WBits'(out_col_ff) + WBits'(1);
      if (out_col_inc >= eff_w) begin
         adv_out_col = '0;
         adv_out_row = out_row_ff + RowBits'(1);
      end else begin
         adv_out_col = out_col_inc[ColBits-1:0];
         adv_out_row = out_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cmd.prep) begin
         in_col_ff  <= is_pixel ? adv_in_col : c_in_col;
         in_row_ff  <= is_pixel ? adv_in_row : c_in_row;
         out_col_ff <= c_out_col;
         out_row_ff <= c_out_row;
      end else if (cmd.push) begin
         out_col_ff <= adv_out_col;
         out_row_ff <= adv_out_row;
      end
   end

   // a result is due once the bottom-right in-frame neighbor has arrived
   logic [RowBits:0] tr, row_ext;
   logic [WBits:0]   tc, col_ext;
   logic             pending;

   always_comb begin
      row_ext = (RowBits+1)'(out_row_ff) + (RowBits+1)'(Kr);
      tr      = (row_ext > (RowBits+1)'(eff_h - RowBits'(1))) ?
                (RowBits+1)'(eff_h - RowBits'(1)) : row_ext;
      col_ext = (WBits+1)'(out_col_ff) + (WBits+1)'(Kr);
      tc      = (col_ext > (WBits+1)'(eff_w - WBits'(1))) ?
                (WBits+1)'(eff_w - WBits'(1)) : col_ext;
      pending = !frame_done &&
                (((RowBits+1)'(in_row_ff) > tr) ||
                 (((RowBits+1)'(in_row_ff) == tr) && ((WBits+1)'(in_col_ff) > tc)));
   end

   // tap walk
   logic [TapBits-1:0] ty_ff, tx_ff;
   logic [RowBits+1:0] nr;
   logic [ColBits+1:0] nc;
   logic               tap_inside;
   logic [1:0]         ay, ax;
   logic               last_tap;

   always_comb begin
      nr = (RowBits+2)'(out_row_ff) + (RowBits+2)'(ty_ff) - (RowBits+2)'(Kr);
      nc = (ColBits+2)'(out_col_ff) + (ColBits+2)'(tx_ff) - (ColBits+2)'(Kr);
      tap_inside = !nr[RowBits+1] && (nr < (RowBits+2)'(eff_h)) &&
                   !nc[ColBits+1] && (nc < (ColBits+2)'(eff_w));
      ay = (ty_ff < TapBits'(Kr)) ? 2'(TapBits'(Kr) - ty_ff) : 2'(ty_ff - TapBits'(Kr));
      ax = (tx_ff < TapBits'(Kr)) ? 2'(TapBits'(Kr) - tx_ff) : 2'(tx_ff - TapBits'(Kr));
      last_tap = (ty_ff == TapBits'(usm_pkg::Taps - 1)) &&
                 (tx_ff == TapBits'(usm_pkg::Taps - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ty_ff <= '0;
         tx_ff <= '0;
      end else if (cmd.clear_acc) begin
         ty_ff <= '0;
         tx_ff <= '0;
      end else if (cmd.tap_acc) begin
         if (tx_ff == TapBits'(usm_pkg::Taps - 1)) begin
            tx_ff <= '0;
            ty_ff <= ty_ff + TapBits'(1);
         end else begin
            tx_ff <= tx_ff + TapBits'(1);
         end
      end
   end

   // row store: one write, one registered read per cycle
   logic [31:0]         row_store_mem [Depth];
   logic [31:0]         rd_data_ff;
   logic                mem_rd;
   logic [AddrBits-1:0] rd_addr, wr_addr;

   always_comb begin
      mem_rd  = cmd.tap_rd || cmd.cen_rd;
      rd_addr = cmd.cen_rd ? addr_of(out_row_ff[usm_pkg::SlotBits-1:0], out_col_ff)
                           : addr_of(nr[usm_pkg::SlotBits-1:0], nc[ColBits-1:0]);
      wr_addr = addr_of(c_in_row[usm_pkg::SlotBits-1:0], c_in_col);
   end

   always_ff @(posedge clock) begin
      if (cmd.prep && is_pixel) begin
         row_store_mem[wr_addr] <= {req_ff.in_opacity, req_ff.in_blue,
                                    req_ff.in_green, req_ff.in_red};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) rd_data_ff <= row_store_mem[rd_addr];
   end

   // multiply-accumulate
   logic              inside_ff;
   logic [WtBits-1:0] wt_ff;
   logic [AccBits-1:0] acc_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.tap_rd) begin
         inside_ff <= tap_inside;
         wt_ff     <= usm_pkg::WeightRom[ay][ax];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.clear_acc) begin
            acc_ff[c] <= '0;
         end else if (cmd.tap_acc && inside_ff) begin
            acc_ff[c] <= acc_ff[c] + AccBits'(wt_ff) * AccBits'(rd_data_ff[8*c +: 8]);
         end
      end
   end

   // sharpen stage
   logic [7:0] sharp_ff [3];
   logic [7:0] opacity_ff;

   always_ff @(posedge clock) begin
      if (cmd.sharpen) begin
         for (int c = 0; c < 3; c++) begin
            sharp_ff[c] <= sharpen(rd_data_ff[8*c +: 8], blur_of(acc_ff[c]), gain_ff);
         end
         opacity_ff <= rd_data_ff[31:24];
      end
   end

   // output register
   logic                  rsp_valid_ff;
   usm_pkg::rsp_data_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff.out_red       <= sharp_ff[0];
         rsp_data_ff.out_green     <= sharp_ff[1];
         rsp_data_ff.out_blue      <= sharp_ff[2];
         rsp_data_ff.out_opacity   <= opacity_ff;
         rsp_data_ff.last_of_frame <= adv_out_row >= eff_h;
      end
   end

   assign sts = '{pending: pending, last_tap: last_tap,
                  out_free: (!rsp_valid_ff || rsp_ready)};
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

>>> rtl/unsharp_mask_sharpen_rgba.sv
// Unsharp-mask sharpener, RGBA raster stream, 7x7 Gaussian blur. One transaction at a time.
// Sequence: accept, update, check, then 49 taps through the row store's single read port, each
// an address step followed by a multiply-accumulate step, then center read, sharpen and output.
// A transaction that releases no result frees the input after update and check. A new
// transaction is taken only once the last one is done; a stalled output holds the output step.
// Reset: counters cleared, registers to 1024 x 768 and gain 24; the row store is not cleared.
module unsharp_mask_sharpen_rgba #(
   parameter int MAX_WIDTH = usm_pkg::DefaultMaxWidth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [usm_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [usm_pkg::CsrDataBits-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  usm_pkg::req_data_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output usm_pkg::rsp_data_type            rsp_data
);

   usm_pkg::cmd_type cmd;
   usm_pkg::sts_type sts;

   usm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   usm_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a transaction is in progress");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten before it was taken");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

endmodule
